>>> rtl/gle_pkg.sv
// Shared types and constants for the GIF LZW encoder.
// No dependencies.
package gle_pkg;

   localparam int TABLE_ENTRIES  = 4096;
   localparam int ADDR_W         = 12;
   localparam int LINK_W         = 13;
   localparam int MAX_CODE_WIDTH = 12;
   localparam int ROOT_MAX       = 256;
   localparam logic [LINK_W-1:0] NO_CODE = 13'h1000;

   typedef enum logic [3:0] {
      S_IDLE, S_EMIT, S_START, S_RD_FC, S_RD_SIB, S_MISS, S_ADD,
      S_REINIT, S_TAIL, S_END, S_FLUSH, S_DONE
   } state_type;

   typedef struct packed {
      logic              emit;
      logic              flush;
      logic              done;
      logic              last;
      logic [ADDR_W-1:0] code;
      logic [3:0]        width;
   } pk_cmd_type;

endpackage

>>> rtl/gle_ram.sv
// Generic single-port synchronous RAM, registered read.
// No dependencies.
module gle_ram #(
   parameter int WIDTH  = 8,
   parameter int ADDR_W = 12
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wdata,
   output logic [WIDTH-1:0]  rdata
);
   logic [WIDTH-1:0] mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

>>> rtl/gle_pack.sv
// LSB-first bit packer with one held byte and the output register.
// Depends on gle_pkg.
module gle_pack
   import gle_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  pk_cmd_type cmd,
   output logic       idle,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_stream_last
);
   logic [19:0] acc_ff;
   logic [4:0]  fill_ff;
   logic [7:0]  held_ff;
   logic        held_v_ff, done_p_ff, done_last_ff;
   logic        rsp_v_ff, run_ff, str_ff;
   logic [7:0]  byte_ff;
   logic        rsp_free, byte_go, done_go, held_ok, out_load;
   logic [11:0] masked;

   assign rsp_free = !rsp_v_ff || rsp_ready;
   assign held_ok  = !held_v_ff || rsp_free;
   assign byte_go  = (fill_ff >= 5'd8) && held_ok;
   assign done_go  = done_p_ff && (fill_ff < 5'd8) && held_ok;
   assign out_load = (byte_go || done_go) && held_v_ff;
   assign idle     = (fill_ff < 5'd8) && !done_p_ff;
   assign masked   = cmd.code & ~(12'hFFF << cmd.width);

   assign rsp_valid       = rsp_v_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_run_last    = run_ff;
   assign rsp_stream_last = str_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         fill_ff   <= '0;
         held_v_ff <= 1'b0;
         done_p_ff <= 1'b0;
         rsp_v_ff  <= 1'b0;
      end else begin
         if (out_load) begin
            rsp_v_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_v_ff <= 1'b0;
         end
         if (byte_go) begin
            if (held_v_ff) begin
               byte_ff  <= held_ff;
               run_ff   <= 1'b0;
               str_ff   <= 1'b0;
            end
            held_ff   <= acc_ff[7:0];
            held_v_ff <= 1'b1;
            acc_ff    <= acc_ff >> 8;
            fill_ff   <= fill_ff - 5'd8;
         end else if (done_go) begin
            if (held_v_ff) begin
               byte_ff  <= held_ff;
               run_ff   <= 1'b1;
               str_ff   <= done_last_ff;
            end
            held_v_ff <= 1'b0;
            done_p_ff <= 1'b0;
         end else if (cmd.emit) begin
            acc_ff  <= acc_ff | (20'(masked) << fill_ff);
            fill_ff <= fill_ff + 5'(cmd.width);
         end else if (cmd.flush) begin
            // zero padding is already in acc
            if (fill_ff != 5'd0) begin
               fill_ff <= 5'd8;
            end
         end else if (cmd.done) begin
            done_p_ff    <= 1'b1;
            done_last_ff <= cmd.last;
         end
      end
   end
endmodule

>>> rtl/gif_lzw_encoder_core.sv
// GIF LZW encoder top level: control sequencer and dictionary memories.
// Depends on gle_pkg, gle_ram, gle_pack.
//
// Usage: one palette index per req item (req_image_end on the last pixel).
// Packed code-stream bytes leave on rsp, LSB-first, one byte per item; the
// last byte caused by an input carries rsp_run_last, the final byte of an
// image also rsp_stream_last. csr_wr_en/csr_wr_data set the root code size
// (reset 8, clamped to 2..8); write it only while the block is idle.
// Flow: one input item at a time, req_ready only in idle. A hit walks
// L >= 1 links in the {entry_char,next_sibling} RAM, one registered read
// per link; a miss walks L >= 0 links, then emits a code, writes the new
// entry to both RAMs and links it as its parent's first child. The first
// pixel of an image also emits a clear code; the last pixel adds the end
// code and the flush. Each emission and the item end also wait until the
// packer holds fewer than 8 bits; bytes leave one per cycle while rsp_ready is high.
// Reset: control clears, the root first_child valid bits clear, and the
// first pixel starts an image with a clear code and fresh table.
// Stall: when rsp_ready is low the packer holds, the sequencer waits
// before its next emission, and req_ready stays low until the item ends.
module gif_lzw_encoder_core
   import gle_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_pixel_index,
   input  logic       req_image_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_stream_last,
   input  logic       csr_wr_en,
   input  logic [3:0] csr_wr_data
);
   state_type state_ff, state_in, ret_ff, ret_in;

   logic [3:0]        min_size_ff, m_ff, m_in, m_eff, cw_ff, cw_in;
   logic [LINK_W-1:0] nfc_ff, nfc_in, pend_ff, pend_in, c_ff, c_in;
   logic [LINK_W-1:0] fc_ff, fc_in, ecode_ff, ecode_in, clr_code, fc_val;
   logic [7:0]        pix_ff, pix_in;
   logic              last_ff, last_in, started_ff, started_in;
   logic              fc_none_ff, fc_none_in;
   logic [ROOT_MAX-1:0] vld_ff, vld_in;

   // first_child RAM
   logic              a_we;
   logic [ADDR_W-1:0] a_addr;
   logic [LINK_W-1:0] a_wdata, a_rdata;
   // {entry_char, next_sibling} RAM
   logic              b_we;
   logic [ADDR_W-1:0] b_addr;
   logic [20:0]       b_wdata, b_rdata;

   pk_cmd_type cmd;
   logic       pk_idle;

   gle_ram #(.WIDTH(LINK_W), .ADDR_W(ADDR_W)) u_fc (
      .clock(clock), .we(a_we), .addr(a_addr), .wdata(a_wdata), .rdata(a_rdata));

   gle_ram #(.WIDTH(21), .ADDR_W(ADDR_W)) u_es (
      .clock(clock), .we(b_we), .addr(b_addr), .wdata(b_wdata), .rdata(b_rdata));

   gle_pack u_pack (
      .clock(clock), .reset(reset), .cmd(cmd), .idle(pk_idle),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_out_byte(rsp_out_byte),
      .rsp_run_last(rsp_run_last), .rsp_stream_last(rsp_stream_last));

   assign m_eff      = (min_size_ff < 4'd2) ? 4'd2 : ((min_size_ff > 4'd8) ? 4'd8 : min_size_ff);
   assign clr_code   = LINK_W'(1) << m_ff;
   assign fc_val     = fc_none_ff ? NO_CODE : a_rdata;
   assign req_ready  = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         ret_ff      <= S_IDLE;
         min_size_ff <= 4'd8;
         started_ff  <= 1'b0;
         vld_ff      <= '0;
         pend_ff     <= NO_CODE;
         nfc_ff      <= LINK_W'(258);
         cw_ff       <= 4'd9;
      end else begin
         state_ff   <= state_in;
         ret_ff     <= ret_in;
         started_ff <= started_in;
         vld_ff     <= vld_in;
         pend_ff    <= pend_in;
         nfc_ff     <= nfc_in;
         cw_ff      <= cw_in;
         if (csr_wr_en) begin
            min_size_ff <= csr_wr_data;
         end
      end
      m_ff       <= m_in;
      pix_ff     <= pix_in;
      last_ff    <= last_in;
      c_ff       <= c_in;
      fc_ff      <= fc_in;
      ecode_ff   <= ecode_in;
      fc_none_ff <= fc_none_in;
   end

   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      m_in       = m_ff;
      pix_in     = pix_ff;
      last_in    = last_ff;
      started_in = started_ff;
      vld_in     = vld_ff;
      pend_in    = pend_ff;
      nfc_in     = nfc_ff;
      cw_in      = cw_ff;
      c_in       = c_ff;
      fc_in      = fc_ff;
      ecode_in   = ecode_ff;
      fc_none_in = fc_none_ff;
      a_we       = 1'b0;
      a_addr     = pend_ff[ADDR_W-1:0];
      a_wdata    = NO_CODE;
      b_we       = 1'b0;
      b_addr     = c_ff[ADDR_W-1:0];
      b_wdata    = {pix_ff, fc_ff};
      cmd        = '0;
      cmd.code   = ecode_ff[ADDR_W-1:0];
      cmd.width  = cw_ff;
      cmd.last   = last_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               m_in    = m_eff;
               pix_in  = req_pixel_index & 8'((LINK_W'(1) << m_eff) - LINK_W'(1));
               last_in = req_image_end;
               if (!started_ff) begin
                  // new image: fresh table, then a clear code
                  vld_in     = '0;
                  nfc_in     = (LINK_W'(1) << m_eff) + LINK_W'(2);
                  cw_in      = m_eff + 4'd1;
                  started_in = 1'b1;
                  pend_in    = NO_CODE;
                  ecode_in   = LINK_W'(1) << m_eff;
                  ret_in     = S_START;
                  state_in   = S_EMIT;
               end else begin
                  state_in = S_START;
               end
            end
         end
         S_EMIT: begin
            if (pk_idle) begin
               cmd.emit = 1'b1;
               state_in = ret_ff;
            end
         end
         S_START: begin
            if (pend_ff == NO_CODE) begin
               pend_in  = {5'd0, pix_ff};
               state_in = S_TAIL;
            end else begin
               // roots whose child list was cleared read as empty
               fc_none_in = (pend_ff < LINK_W'(ROOT_MAX)) && !vld_ff[pend_ff[7:0]];
               state_in   = S_RD_FC;
            end
         end
         S_RD_FC: begin
            fc_in = fc_val;
            if (fc_val[ADDR_W]) begin
               ecode_in = pend_ff;
               ret_in   = S_MISS;
               state_in = S_EMIT;
            end else begin
               b_addr   = fc_val[ADDR_W-1:0];
               c_in     = fc_val;
               state_in = S_RD_SIB;
            end
         end
         S_RD_SIB: begin
            if (b_rdata[20:13] == pix_ff) begin
               pend_in  = c_ff;
               state_in = S_TAIL;
            end else if (b_rdata[ADDR_W]) begin
               ecode_in = pend_ff;
               ret_in   = S_MISS;
               state_in = S_EMIT;
            end else begin
               b_addr = b_rdata[ADDR_W-1:0];
               c_in   = b_rdata[LINK_W-1:0];
            end
         end
         S_MISS: begin
            if (!nfc_ff[ADDR_W]) begin
               b_we    = 1'b1;
               b_addr  = nfc_ff[ADDR_W-1:0];
               a_we    = 1'b1;
               a_addr  = nfc_ff[ADDR_W-1:0];
               a_wdata = NO_CODE;
               if (nfc_ff < LINK_W'(ROOT_MAX)) begin
                  vld_in[nfc_ff[7:0]] = 1'b1;
               end
               state_in = S_ADD;
            end else begin
               // table full: clear code, then reset the table
               ecode_in = clr_code;
               ret_in   = S_REINIT;
               state_in = S_EMIT;
            end
         end
         S_ADD: begin
            a_we    = 1'b1;
            a_addr  = pend_ff[ADDR_W-1:0];
            a_wdata = nfc_ff;
            if (pend_ff < LINK_W'(ROOT_MAX)) begin
               vld_in[pend_ff[7:0]] = 1'b1;
            end
            if (nfc_ff == (LINK_W'(1) << cw_ff) && cw_ff < 4'(MAX_CODE_WIDTH)) begin
               cw_in = cw_ff + 4'd1;
            end
            nfc_in   = nfc_ff + LINK_W'(1);
            pend_in  = {5'd0, pix_ff};
            state_in = S_TAIL;
         end
         S_REINIT: begin
            vld_in   = '0;
            nfc_in   = clr_code + LINK_W'(2);
            cw_in    = m_ff + 4'd1;
            pend_in  = {5'd0, pix_ff};
            state_in = S_TAIL;
         end
         S_TAIL: begin
            if (last_ff) begin
               ecode_in = pend_ff;
               ret_in   = S_END;
               state_in = S_EMIT;
            end else begin
               state_in = S_DONE;
            end
         end
         S_END: begin
            ecode_in = clr_code + LINK_W'(1);
            ret_in   = S_FLUSH;
            state_in = S_EMIT;
         end
         S_FLUSH: begin
            if (pk_idle) begin
               cmd.flush  = 1'b1;
               started_in = 1'b0;
               pend_in    = NO_CODE;
               state_in   = S_DONE;
            end
         end
         S_DONE: begin
            if (pk_idle) begin
               cmd.done = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // code width stays in the legal GIF range while an image is open
   assert property (@(posedge clock) disable iff (reset)
      started_ff |-> (cw_ff >= 4'd3 && cw_ff <= 4'(MAX_CODE_WIDTH)))
      else $error("code width out of range");

   // a chain walk only ever follows real table links
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD_SIB) |-> !c_ff[ADDR_W])
      else $error("chain walk on none marker");

   // the free-code counter never passes the table size
   assert property (@(posedge clock) disable iff (reset)
      started_ff |-> (nfc_ff <= LINK_W'(TABLE_ENTRIES)))
      else $error("next free code overflow");
endmodule
